// ===== hdl/mmlt_pkg.sv =====
// ----------------------------------------------------------------------------
// MIDI mapping lookup table package
// Shared sizes, key layout, operation codes and sequencer states.
// ----------------------------------------------------------------------------
package mmlt_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int DATA_BITS   = 16;

  localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);

  localparam int OP_W   = 2;
  localparam int CH_W   = 5;
  localparam int TYPE_W = 8;
  localparam int NUM_W  = 8;
  localparam int EDAT_W = 16;
  localparam int SLOT_W = 6;
  localparam int HIT_W  = 6;
  localparam int USED_W = 7;

  localparam int CMP_W  = ((SLOT_W > CNT_W) ? SLOT_W : CNT_W) + 1;

  typedef enum logic [OP_W-1:0] {
    OP_FIND   = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef struct packed {
    logic [CH_W-1:0]   channel;
    logic [TYPE_W-1:0] msg_type;
    logic [NUM_W-1:0]  msg_number;
  } key_t;

  localparam int KEY_W = $bits(key_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RM_RD,
    ST_RM_WR,
    ST_RESP
  } state_e;

endpackage

// ===== hdl/midi_mapping_lookup_table.sv =====
// ----------------------------------------------------------------------------
// MIDI mapping lookup table
// Table of controller mappings with find, add, remove and clear requests.
// ----------------------------------------------------------------------------
// Usage: present a request on operation_i and the key/data/slot inputs and
// raise start; it is taken at a clock edge where start is high and busy is
// low. busy stays high while the request runs. The result (ok_o, hit_index_o,
// entries_in_use_o) is valid for exactly one cycle with done_o high; the
// receiver cannot stall it, and busy drops in the cycle after done_o.
// Find and add scan the stored keys one per cycle through a single key RAM
// read port and one compare unit, and stop early when a match is found.
// Remove moves the last entry into the freed slot with one RAM read and one
// RAM write, unless the freed slot is already the last one.
// Throughput: one request at a time; the next may be accepted in the cycle
// after done_o.
// Reset: clears the entry count and the sequencer; the key and data RAMs are
// not cleared, since only entries below the count are ever used.
// ----------------------------------------------------------------------------
module midi_mapping_lookup_table (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [mmlt_pkg::OP_W-1:0]    operation_i,
  input  logic [mmlt_pkg::CH_W-1:0]    channel_i,
  input  logic [mmlt_pkg::TYPE_W-1:0]  msg_type_i,
  input  logic [mmlt_pkg::NUM_W-1:0]   msg_number_i,
  input  logic [mmlt_pkg::EDAT_W-1:0]  entry_data_i,
  input  logic [mmlt_pkg::SLOT_W-1:0]  slot_i,
  output logic                         done_o,
  output logic                         ok_o,
  output logic [mmlt_pkg::HIT_W-1:0]   hit_index_o,
  output logic [mmlt_pkg::USED_W-1:0]  entries_in_use_o
);

  import mmlt_pkg::*;

  state_e state_q, state_d;

  op_e                 op_q;
  key_t                query_q;
  logic [DATA_BITS-1:0] data_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    iss_q, iss_d;
  logic                pend_q, pend_d;
  logic [IDX_W-1:0]    cidx_q, cidx_d;
  logic                res_ok_q, res_ok_d;
  logic [IDX_W-1:0]    res_hit_q, res_hit_d;

  logic                accept;
  op_e                 op_in;
  logic                slot_valid;
  logic                slot_last;
  logic                room;
  logic                scan_hit;
  logic                scan_miss;

  logic                key_we;
  logic [IDX_W-1:0]    key_waddr;
  key_t                key_wdata;
  logic [IDX_W-1:0]    rd_addr;
  logic [KEY_W-1:0]    key_rdata;
  key_t                key_rd;
  logic                dat_we;
  logic [IDX_W-1:0]    dat_waddr;
  logic [DATA_BITS-1:0] dat_wdata;
  logic [DATA_BITS-1:0] dat_rdata;
  logic                match_hit;

  assign accept     = start && !busy;
  assign op_in      = op_e'(operation_i);
  assign slot_valid = CMP_W'(slot_i) < CMP_W'(count_q);
  assign slot_last  = (CMP_W'(slot_i) + CMP_W'(1)) == CMP_W'(count_q);
  assign room       = count_q < CNT_W'(MAX_ENTRIES);
  assign key_rd     = key_t'(key_rdata);
  assign scan_hit   = pend_q && match_hit;
  assign scan_miss  = !pend_q && (iss_q == count_q);

  mmlt_match u_match (
    .entry_i (key_rd),
    .query_i (query_q),
    .exact_i (op_q == OP_ADD),
    .hit_o   (match_hit)
  );

  mmlt_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_ENTRIES),
    .AW    (IDX_W)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (key_wdata),
    .raddr_i (rd_addr),
    .rdata_o (key_rdata)
  );

  mmlt_ram #(
    .WIDTH (DATA_BITS),
    .DEPTH (MAX_ENTRIES),
    .AW    (IDX_W)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (dat_we),
    .waddr_i (dat_waddr),
    .wdata_i (dat_wdata),
    .raddr_i (rd_addr),
    .rdata_o (dat_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (op_in)
            OP_FIND, OP_ADD: state_d = ST_SCAN;
            OP_REMOVE:       state_d = (slot_valid && !slot_last) ? ST_RM_RD : ST_RESP;
            OP_CLEAR:        state_d = ST_RESP;
            default:         state_d = ST_RESP;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_hit || scan_miss) begin
          state_d = ST_RESP;
        end
      end
      ST_RM_RD: state_d = ST_RM_WR;
      ST_RM_WR: state_d = ST_RESP;
      ST_RESP:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    count_d   = count_q;
    iss_d     = iss_q;
    pend_d    = pend_q;
    cidx_d    = cidx_q;
    res_ok_d  = res_ok_q;
    res_hit_d = res_hit_q;
    key_we    = 1'b0;
    key_waddr = cidx_q;
    key_wdata = query_q;
    dat_we    = 1'b0;
    dat_waddr = cidx_q;
    dat_wdata = data_q;
    rd_addr   = iss_q[IDX_W-1:0];
    unique case (state_q)
      ST_IDLE: begin
        iss_d     = '0;
        pend_d    = 1'b0;
        if (accept) begin
          res_ok_d  = 1'b0;
          res_hit_d = '0;
          unique case (op_in)
            OP_FIND, OP_ADD: ;
            OP_REMOVE: begin
              res_ok_d = slot_valid;
              if (slot_valid && slot_last) begin
                count_d = count_q - CNT_W'(1);
              end
            end
            OP_CLEAR: begin
              res_ok_d = 1'b1;
              count_d  = '0;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_hit) begin
          res_ok_d = 1'b1;
          if (op_q == OP_FIND) begin
            res_hit_d = cidx_q;
          end else begin
            dat_we = 1'b1;
          end
        end else if (scan_miss) begin
          if (op_q == OP_ADD && room) begin
            res_ok_d  = 1'b1;
            key_we    = 1'b1;
            key_waddr = count_q[IDX_W-1:0];
            dat_we    = 1'b1;
            dat_waddr = count_q[IDX_W-1:0];
            count_d   = count_q + CNT_W'(1);
          end
        end else begin
          pend_d = iss_q < count_q;
          if (iss_q < count_q) begin
            cidx_d = iss_q[IDX_W-1:0];
            iss_d  = iss_q + CNT_W'(1);
          end
        end
      end
      ST_RM_RD: begin
        rd_addr = IDX_W'(count_q - CNT_W'(1));
      end
      ST_RM_WR: begin
        key_we    = 1'b1;
        key_waddr = IDX_W'(slot_q);
        key_wdata = key_rd;
        dat_we    = 1'b1;
        dat_waddr = IDX_W'(slot_q);
        dat_wdata = dat_rdata;
        count_d   = count_q - CNT_W'(1);
      end
      ST_RESP: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      iss_q     <= '0;
      pend_q    <= 1'b0;
      res_ok_q  <= 1'b0;
      res_hit_q <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      iss_q     <= iss_d;
      pend_q    <= pend_d;
      res_ok_q  <= res_ok_d;
      res_hit_q <= res_hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cidx_q <= cidx_d;
    if (accept) begin
      op_q                <= op_in;
      query_q.channel     <= channel_i;
      query_q.msg_type    <= msg_type_i;
      query_q.msg_number  <= msg_number_i;
      data_q              <= DATA_BITS'(entry_data_i);
      slot_q              <= slot_i;
    end
  end

  assign busy             = (state_q != ST_IDLE);
  assign done_o           = (state_q == ST_RESP);
  assign ok_o             = res_ok_q;
  assign hit_index_o      = HIT_W'(res_hit_q);
  assign entries_in_use_o = USED_W'(count_q);

endmodule

// ===== hdl/mmlt_ram.sv =====
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mmlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/mmlt_match.sv =====
// ----------------------------------------------------------------------------
// Key compare unit
// Compares one stored key with the request key, exact or with channel wildcard.
// ----------------------------------------------------------------------------
module mmlt_match (
  input  mmlt_pkg::key_t entry_i,
  input  mmlt_pkg::key_t query_i,
  input  logic           exact_i,
  output logic           hit_o
);

  import mmlt_pkg::*;

  logic body_eq;
  logic ch_eq;
  logic ch_any;

  assign body_eq = (entry_i.msg_type == query_i.msg_type) &&
                   (entry_i.msg_number == query_i.msg_number);
  assign ch_eq   = (entry_i.channel == query_i.channel);
  assign ch_any  = (entry_i.channel == '0);
  assign hit_o   = body_eq && (ch_eq || (!exact_i && ch_any));

endmodule
